// ===== sv/pngcsp_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PNG chunk stream parser package
// Parse phases, event codes, chunk kinds and the PNG signature bytes.
// ----------------------------------------------------------------------------
package pngcsp_pkg;

  // Parse phase, one-hot
  typedef enum logic [6:0] {
    PH_SIG  = 7'b0000001,
    PH_LEN  = 7'b0000010,
    PH_TYPE = 7'b0000100,
    PH_DATA = 7'b0001000,
    PH_CRC  = 7'b0010000,
    PH_DONE = 7'b0100000,
    PH_HALT = 7'b1000000
  } phase_t;

  // Event reported with every byte
  typedef enum logic [3:0] {
    EV_BUSY      = 4'd0,
    EV_SIG_OK    = 4'd1,
    EV_TYPE_DONE = 4'd2,
    EV_LEN_READY = 4'd3,
    EV_CHUNK_END = 4'd4,
    EV_IEND_END  = 4'd5,
    EV_BAD_SIG   = 4'd6,
    EV_BAD_TYPE  = 4'd7,
    EV_AFTER_END = 4'd8
  } event_t;

  // Chunk kind
  typedef enum logic [1:0] {
    KIND_IHDR    = 2'd0,
    KIND_IDAT    = 2'd1,
    KIND_IEND    = 2'd2,
    KIND_UNKNOWN = 2'd3
  } kind_t;

  localparam logic [31:0] TYPE_IHDR = 32'h4948_4452;
  localparam logic [31:0] TYPE_IDAT = 32'h4944_4154;
  localparam logic [31:0] TYPE_IEND = 32'h4945_4E44;

  localparam int unsigned SIG_LEN = 8;
  localparam int unsigned FIELD_LEN = 4;

  // PNG file signature, byte by byte
  function automatic logic [7:0] sig_byte(input logic [2:0] idx);
    logic [7:0] val;
    unique case (idx)
      3'd0: val = 8'h89;
      3'd1: val = 8'h50;
      3'd2: val = 8'h4e;
      3'd3: val = 8'h47;
      3'd4: val = 8'h0d;
      3'd5: val = 8'h0a;
      3'd6: val = 8'h1a;
      3'd7: val = 8'h0a;
      default: val = 8'h00;
    endcase
    return val;
  endfunction

endpackage

// ===== sv/png_chunk_stream_parser.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PNG chunk stream parser
// Checks the PNG signature, frames chunks by their length field, classifies
// the chunk type and captures image width and height from IHDR.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one file byte per request; in_tuser set on the first byte of a
//           file restarts parsing from the signature.
//   out_* : one result per input byte: event code and chunk kind in out_tuser,
//           chunk length, image width and height in out_tdata.
//   A byte lands in the input register when it is accepted; its result is
//   then registered in the result register, which raises out_tvalid, as
//   soon as that register is free. The state update is a single pass of logic on the
//   input register; one byte per cycle is sustained while the receiver
//   takes results.
//   When the receiver stalls, the result register holds and the input
//   register fills; in_tready then drops until out_tready returns.
//   Reset (rst_n low, synchronous) empties both registers and returns the
//   parser to the signature phase with length, type, kind, width and height
//   cleared. A bad signature or unknown chunk type halts the parser; it and
//   every byte after IEND then report "byte after end" until restart.
// ----------------------------------------------------------------------------
module png_chunk_stream_parser (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] data_byte
  input  logic        in_tuser,   // [0] start_of_file
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [95:0] out_tdata,  // [31:0] chunk_length, [63:32] image_width,
                                  // [95:64] image_height
  output logic [5:0]  out_tuser   // [3:0] event_res, [5:4] chunk_kind
);
  import pngcsp_pkg::*;

  // Input register
  logic        in_vld_r;
  logic [7:0]  in_byte_r;
  logic        in_sof_r;

  // Parser state
  phase_t      phase_r, phase_nxt;
  logic [31:0] pos_r, pos_nxt;
  logic [31:0] len_r, len_nxt;
  logic [31:0] typ_r, typ_nxt;
  kind_t       kind_r, kind_nxt;
  logic [31:0] wid_r, wid_nxt;
  logic [31:0] hgt_r, hgt_nxt;

  // Result register
  logic        out_vld_r;
  event_t      ev_r, ev_nxt;
  kind_t       okind_r;
  logic [31:0] olen_r, owid_r, ohgt_r;

  // State seen by the current byte, after an optional restart
  phase_t      ph_c;
  logic [31:0] pos_c, len_c, typ_c, wid_c, hgt_c, pos_inc;
  kind_t       kind_c;
  logic [31:0] typ_shift;

  logic        out_adv;
  logic        process;

  assign out_adv   = !out_vld_r || out_tready;
  assign process   = in_vld_r && out_adv;
  assign in_tready = !in_vld_r || out_adv;

  // Apply restart, then advance the parser by one byte
  always_comb begin
    ph_c    = in_sof_r ? PH_SIG : phase_r;
    pos_c   = in_sof_r ? '0 : pos_r;
    len_c   = in_sof_r ? '0 : len_r;
    typ_c   = in_sof_r ? '0 : typ_r;
    kind_c  = in_sof_r ? KIND_IHDR : kind_r;
    wid_c   = in_sof_r ? '0 : wid_r;
    hgt_c   = in_sof_r ? '0 : hgt_r;
    pos_inc = pos_c + 32'd1;
    typ_shift = {typ_c[23:0], in_byte_r};

    phase_nxt = ph_c;
    pos_nxt   = pos_c;
    len_nxt   = len_c;
    typ_nxt   = typ_c;
    kind_nxt  = kind_c;
    wid_nxt   = wid_c;
    hgt_nxt   = hgt_c;
    ev_nxt    = EV_BUSY;

    unique case (ph_c)
      PH_SIG: begin
        if (in_byte_r != sig_byte(pos_c[2:0])) begin
          ev_nxt    = EV_BAD_SIG;
          phase_nxt = PH_HALT;
        end else if (pos_c >= 32'(SIG_LEN - 1)) begin
          ev_nxt    = EV_SIG_OK;
          phase_nxt = PH_LEN;
          pos_nxt   = '0;
        end else begin
          pos_nxt = pos_inc;
        end
      end
      PH_LEN: begin
        len_nxt = {len_c[23:0], in_byte_r};
        if (pos_c >= 32'(FIELD_LEN - 1)) begin
          ev_nxt    = EV_LEN_READY;
          phase_nxt = PH_TYPE;
          pos_nxt   = '0;
        end else begin
          pos_nxt = pos_inc;
        end
      end
      PH_TYPE: begin
        typ_nxt = typ_shift;
        if (pos_c >= 32'(FIELD_LEN - 1)) begin
          pos_nxt = '0;
          priority if (typ_shift == TYPE_IHDR) kind_nxt = KIND_IHDR;
          else if (typ_shift == TYPE_IDAT) kind_nxt = KIND_IDAT;
          else if (typ_shift == TYPE_IEND) kind_nxt = KIND_IEND;
          else kind_nxt = KIND_UNKNOWN;
          if (kind_nxt == KIND_UNKNOWN) begin
            ev_nxt    = EV_BAD_TYPE;
            phase_nxt = PH_HALT;
          end else begin
            ev_nxt    = EV_TYPE_DONE;
            phase_nxt = (len_c == '0) ? PH_CRC : PH_DATA;
          end
        end else begin
          pos_nxt = pos_inc;
        end
      end
      PH_DATA: begin
        // Shift the first eight IHDR bytes into width, then height
        if (kind_c == KIND_IHDR) begin
          if (pos_c < 32'd4) begin
            wid_nxt = {wid_c[23:0], in_byte_r};
          end else if (pos_c < 32'd8) begin
            hgt_nxt = {hgt_c[23:0], in_byte_r};
          end
        end
        if (pos_inc == len_c) begin
          phase_nxt = PH_CRC;
          pos_nxt   = '0;
        end else begin
          pos_nxt = pos_inc;
        end
      end
      PH_CRC: begin
        if (pos_c >= 32'(FIELD_LEN - 1)) begin
          pos_nxt = '0;
          if (kind_c == KIND_IEND) begin
            ev_nxt    = EV_IEND_END;
            phase_nxt = PH_DONE;
          end else begin
            ev_nxt    = EV_CHUNK_END;
            phase_nxt = PH_LEN;
          end
        end else begin
          pos_nxt = pos_inc;
        end
      end
      PH_DONE, PH_HALT: begin
        ev_nxt = EV_AFTER_END;
      end
      default: begin
        ev_nxt = EV_AFTER_END;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
      phase_r   <= PH_SIG;
      pos_r     <= '0;
      len_r     <= '0;
      typ_r     <= '0;
      kind_r    <= KIND_IHDR;
      wid_r     <= '0;
      hgt_r     <= '0;
    end else begin
      if (in_tready) begin
        in_vld_r <= in_tvalid;
      end
      if (process) begin
        out_vld_r <= 1'b1;
      end else if (out_tready) begin
        out_vld_r <= 1'b0;
      end
      if (process) begin
        phase_r <= phase_nxt;
        pos_r   <= pos_nxt;
        len_r   <= len_nxt;
        typ_r   <= typ_nxt;
        kind_r  <= kind_nxt;
        wid_r   <= wid_nxt;
        hgt_r   <= hgt_nxt;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      in_byte_r <= in_tdata;
      in_sof_r  <= in_tuser;
    end
    if (process) begin
      ev_r    <= ev_nxt;
      okind_r <= kind_nxt;
      olen_r  <= len_nxt;
      owid_r  <= wid_nxt;
      ohgt_r  <= hgt_nxt;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {ohgt_r, owid_r, olen_r};
  assign out_tuser  = {okind_r, ev_r};

  // Data phase never runs past the chunk length
  a_data_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_DATA |-> pos_r < len_r)
    else $error("data byte position past chunk length");

  // An unknown kind always halts the parser
  a_unknown_halts: assert property (@(posedge clk) disable iff (!rst_n)
    kind_r == KIND_UNKNOWN |-> phase_r == PH_HALT)
    else $error("unknown chunk kind without halt");

  // Width changes only from IHDR data or a restart
  a_width_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !(process && (phase_r == PH_DATA || in_sof_r)) |=> $stable(wid_r))
    else $error("image width changed outside IHDR data");

  // A result is taken from the input register only when one is present
  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_vld_r && !in_vld_r) |=> !out_vld_r)
    else $error("result appeared without an input byte");

endmodule
